[hdl/lpfr_pkg.sv]
// Shared types and constants for the length-prefixed frame receiver.
`timescale 1ns / 1ps

package lpfr_pkg;

  localparam logic [7:0]  START_CODE_RESET = 8'h01;
  localparam logic [15:0] NO_LENGTH        = 16'hFFFF;

  typedef enum logic [1:0] {
    PH_WAIT    = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_HEADER   = 2'd0,
    ST_PAYLOAD  = 2'd1,
    ST_BADSTART = 2'd2,
    ST_LINEERR  = 2'd3
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [15:0] frame_length;
    logic        last;
  } result_t;

endpackage

[hdl/lpfr_parser.sv]
// Frame state machine: header and payload tracking, one result per received byte.
`timescale 1ns / 1ps

module lpfr_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_wdata,
  input  logic                  accept,
  input  logic [7:0]            rx_byte,
  input  logic [2:0]            line_errors,
  output lpfr_pkg::result_t     result
);

  lpfr_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  start_code_r;
  logic [7:0]  length_high_r, length_high_nxt;
  logic        len_seen_r, len_seen_nxt;
  logic [15:0] expected_len_r, expected_len_nxt;
  logic [15:0] payload_count_r, payload_count_nxt;
  logic [15:0] count_inc;
  logic [15:0] rx_length;

  assign count_inc = payload_count_r + 16'd1;
  assign rx_length = {length_high_r, rx_byte};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_code_r <= lpfr_pkg::START_CODE_RESET;
    end else if (cfg_we) begin
      start_code_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= lpfr_pkg::PH_WAIT;
      length_high_r   <= 8'd0;
      len_seen_r      <= 1'b0;
      expected_len_r  <= lpfr_pkg::NO_LENGTH;
      payload_count_r <= 16'd0;
    end else if (accept) begin
      phase_r         <= phase_nxt;
      length_high_r   <= length_high_nxt;
      len_seen_r      <= len_seen_nxt;
      expected_len_r  <= expected_len_nxt;
      payload_count_r <= payload_count_nxt;
    end
  end

  // next state
  always_comb begin
    phase_nxt         = lpfr_pkg::PH_WAIT;
    length_high_nxt   = 8'd0;
    len_seen_nxt      = 1'b0;
    expected_len_nxt  = lpfr_pkg::NO_LENGTH;
    payload_count_nxt = 16'd0;
    if (line_errors == 3'd0) begin
      unique case (phase_r)
        lpfr_pkg::PH_LENGTH: begin
          if (!len_seen_r) begin
            phase_nxt       = lpfr_pkg::PH_LENGTH;
            length_high_nxt = rx_byte;
            len_seen_nxt    = 1'b1;
          end else if (rx_length != 16'd0) begin
            phase_nxt        = lpfr_pkg::PH_PAYLOAD;
            length_high_nxt  = length_high_r;
            len_seen_nxt     = 1'b1;
            expected_len_nxt = rx_length;
          end
        end
        lpfr_pkg::PH_PAYLOAD: begin
          if (count_inc != expected_len_r) begin
            phase_nxt         = lpfr_pkg::PH_PAYLOAD;
            length_high_nxt   = length_high_r;
            len_seen_nxt      = len_seen_r;
            expected_len_nxt  = expected_len_r;
            payload_count_nxt = count_inc;
          end
        end
        default: begin
          if (rx_byte == start_code_r) begin
            phase_nxt = lpfr_pkg::PH_LENGTH;
          end
        end
      endcase
    end
  end

  // result
  always_comb begin
    result.status        = lpfr_pkg::ST_HEADER;
    result.payload_byte  = 8'd0;
    result.payload_index = 16'd0;
    result.frame_length  = lpfr_pkg::NO_LENGTH;
    result.last          = 1'b0;
    if (line_errors != 3'd0) begin
      result.status       = lpfr_pkg::ST_LINEERR;
      result.frame_length = expected_len_r;
      result.last         = 1'b1;
    end else begin
      unique case (phase_r)
        lpfr_pkg::PH_LENGTH: begin
          if (len_seen_r) begin
            result.frame_length = rx_length;
            result.last         = (rx_length == 16'd0);
          end
        end
        lpfr_pkg::PH_PAYLOAD: begin
          result.status        = lpfr_pkg::ST_PAYLOAD;
          result.payload_byte  = rx_byte;
          result.payload_index = payload_count_r;
          result.frame_length  = expected_len_r;
          result.last          = (count_inc == expected_len_r);
        end
        default: begin
          if (rx_byte != start_code_r) begin
            result.status = lpfr_pkg::ST_BADSTART;
            result.last   = 1'b1;
          end
        end
      endcase
    end
  end

endmodule

[hdl/lpfr_out_skid.sv]
// Result register with a skid stage so input can continue while the output stalls.
`timescale 1ns / 1ps

module lpfr_out_skid (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  lpfr_pkg::result_t     push_data,
  input  logic                  out_stall,
  output logic                  out_valid,
  output lpfr_pkg::result_t     out_data,
  output logic                  full
);

  logic              main_valid_r;
  logic              skid_valid_r;
  lpfr_pkg::result_t main_r;
  lpfr_pkg::result_t skid_r;
  logic              take;

  assign take      = main_valid_r && !out_stall;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;
  assign full      = skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      priority if (push) begin
        if (!main_valid_r || take) begin
          main_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (take) begin
        main_valid_r <= skid_valid_r;
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= main_valid_r;
        skid_valid_r <= skid_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (push) begin
      if (!main_valid_r || take) begin
        main_r <= push_data;
      end else begin
        skid_r <= push_data;
      end
    end else if (take && skid_valid_r) begin
      main_r <= skid_r;
    end else begin
      main_r <= main_r;
      skid_r <= skid_r;
    end
  end

endmodule

[hdl/length_prefixed_frame_receiver_top.sv]
// Top level of the length-prefixed frame receiver.
`timescale 1ns / 1ps

// Takes one received byte with its line-error flags per transaction and returns one
// result per byte: a header byte, a payload byte with index, a bad start code or a
// line error, with out_last marking the byte that ends a frame. A frame is the
// start code, a 16-bit big-endian length, then that many payload bytes. One byte is
// accepted every cycle while in_stall is low, and its result is registered in the
// output stage. A two-entry output stage (result register plus skid register) lets
// input continue while the output is stalled; in_stall rises once both are full.
// cfg_we writes the start code (reset value 0x01) and is meant for idle time.

module length_prefixed_frame_receiver_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic [2:0]  in_line_errors,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [7:0]  out_payload_byte,
  output logic [15:0] out_payload_index,
  output logic [15:0] out_frame_length,
  output logic        out_last
);

  logic              accept;
  logic              full;
  lpfr_pkg::result_t result;
  lpfr_pkg::result_t out_data;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  lpfr_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .accept      (accept),
    .rx_byte     (in_rx_byte),
    .line_errors (in_line_errors),
    .result      (result)
  );

  lpfr_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (result),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .full      (full)
  );

  assign out_status        = out_data.status;
  assign out_payload_byte  = out_data.payload_byte;
  assign out_payload_index = out_data.payload_index;
  assign out_frame_length  = out_data.frame_length;
  assign out_last          = out_data.last;

endmodule

[hdl/lpfr_checker.sv]
// Port-level checks for the frame receiver and their bind to the top level.
`timescale 1ns / 1ps

module lpfr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [7:0]  out_payload_byte,
  input logic [15:0] out_payload_index,
  input logic [15:0] out_frame_length,
  input logic        out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_last)
      && $stable(out_payload_byte) && $stable(out_frame_length))
    else $error("stalled output transaction changed");

  a_nonpayload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != lpfr_pkg::ST_PAYLOAD)
      |-> (out_payload_byte == 8'd0) && (out_payload_index == 16'd0))
    else $error("payload fields nonzero outside payload");

  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_status == lpfr_pkg::ST_BADSTART) ||
                  (out_status == lpfr_pkg::ST_LINEERR)) |-> out_last)
    else $error("error transaction without last");

  a_badstart_nolen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == lpfr_pkg::ST_BADSTART)
      |-> (out_frame_length == lpfr_pkg::NO_LENGTH))
    else $error("bad start code with a known length");

endmodule

bind length_prefixed_frame_receiver_top lpfr_checker u_lpfr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_payload_byte  (out_payload_byte),
  .out_payload_index (out_payload_index),
  .out_frame_length  (out_frame_length),
  .out_last          (out_last)
);

[tb/sv/length_prefixed_frame_receiver_top_tb.sv]
// Self-checking testbench for the length-prefixed frame receiver top level.
`timescale 1ns / 1ps

module length_prefixed_frame_receiver_top_tb;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int N_DIR = 21;

  localparam lpfr_pkg::result_t NO_CHECK      = '0;
  localparam lpfr_pkg::result_t HDR_OPEN      =
    '{lpfr_pkg::ST_HEADER, 8'h00, 16'h0000, lpfr_pkg::NO_LENGTH, 1'b0};
  localparam lpfr_pkg::result_t BAD_START     =
    '{lpfr_pkg::ST_BADSTART, 8'h00, 16'h0000, lpfr_pkg::NO_LENGTH, 1'b1};
  localparam lpfr_pkg::result_t LINE_ERR_OPEN =
    '{lpfr_pkg::ST_LINEERR, 8'h00, 16'h0000, lpfr_pkg::NO_LENGTH, 1'b1};

  typedef struct {
    logic [7:0]        rx;
    logic [2:0]        errs;
    bit                typed;
    lpfr_pkg::result_t want;
  } dir_row_t;

  dir_row_t dir_tab [N_DIR] = '{
    '{8'h00, 3'b000, 1'b1, BAD_START},
    '{8'hFF, 3'b000, 1'b1, BAD_START},
    '{8'h01, 3'b000, 1'b1, HDR_OPEN},
    '{8'h00, 3'b000, 1'b1, HDR_OPEN},
    '{8'h00, 3'b000, 1'b1, '{lpfr_pkg::ST_HEADER, 8'h00, 16'h0000, 16'h0000, 1'b1}},
    '{8'h01, 3'b000, 1'b1, HDR_OPEN},
    '{8'h00, 3'b000, 1'b1, HDR_OPEN},
    '{8'h03, 3'b000, 1'b1, '{lpfr_pkg::ST_HEADER, 8'h00, 16'h0000, 16'h0003, 1'b0}},
    '{8'hFF, 3'b000, 1'b0, NO_CHECK},
    '{8'h00, 3'b000, 1'b0, NO_CHECK},
    '{8'hA5, 3'b000, 1'b0, NO_CHECK},
    '{8'h01, 3'b000, 1'b1, HDR_OPEN},
    '{8'h12, 3'b001, 1'b1, LINE_ERR_OPEN},
    '{8'h01, 3'b000, 1'b1, HDR_OPEN},
    '{8'h00, 3'b000, 1'b1, HDR_OPEN},
    '{8'h02, 3'b000, 1'b1, '{lpfr_pkg::ST_HEADER, 8'h00, 16'h0000, 16'h0002, 1'b0}},
    '{8'h55, 3'b000, 1'b0, NO_CHECK},
    '{8'h77, 3'b100, 1'b1, '{lpfr_pkg::ST_LINEERR, 8'h00, 16'h0000, 16'h0002, 1'b1}},
    '{8'hFF, 3'b010, 1'b1, LINE_ERR_OPEN},
    '{8'h01, 3'b000, 1'b1, HDR_OPEN},
    '{8'hFF, 3'b111, 1'b1, LINE_ERR_OPEN}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = 8'h00;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic [2:0]  in_line_errors = 3'b000;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [7:0]  out_payload_byte;
  logic [15:0] out_payload_index;
  logic [15:0] out_frame_length;
  logic        out_last;

  length_prefixed_frame_receiver_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .in_line_errors   (in_line_errors),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_payload_byte (out_payload_byte),
    .out_payload_index(out_payload_index),
    .out_frame_length (out_frame_length),
    .out_last         (out_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [7:0]        code;
  lpfr_pkg::phase_t  ph;
  logic [7:0]        len_hi;
  logic              len_seen;
  logic [15:0]       want_len;
  logic [15:0]       pay_count;

  lpfr_pkg::result_t pending_results [$];
  int      mismatches = 0;
  int      bytes_sent = 0;
  int      cycles = 0;
  bit      calm = 1'b0;
  bit      frame_over = 1'b0;

  function automatic void rewind_frame();
    ph = lpfr_pkg::PH_WAIT;
    len_hi = 8'h00;
    len_seen = 1'b0;
    want_len = lpfr_pkg::NO_LENGTH;
    pay_count = 16'h0000;
  endfunction

  function automatic lpfr_pkg::result_t deframe(input logic [7:0] b, input logic [2:0] e);
    lpfr_pkg::result_t r;
    r = HDR_OPEN;
    if (e != 3'b000) begin
      r.status = lpfr_pkg::ST_LINEERR;
      r.frame_length = want_len;
      r.last = 1'b1;
      rewind_frame();
    end else begin
      case (ph)
        lpfr_pkg::PH_LENGTH: begin
          if (!len_seen) begin
            len_hi = b;
            len_seen = 1'b1;
          end else begin
            want_len = {len_hi, b};
            r.frame_length = want_len;
            if (want_len == 16'h0000) begin
              r.last = 1'b1;
              rewind_frame();
            end else begin
              ph = lpfr_pkg::PH_PAYLOAD;
              pay_count = 16'h0000;
            end
          end
        end
        lpfr_pkg::PH_PAYLOAD: begin
          r.status = lpfr_pkg::ST_PAYLOAD;
          r.payload_byte = b;
          r.payload_index = pay_count;
          r.frame_length = want_len;
          pay_count = pay_count + 16'd1;
          if (pay_count == want_len) begin
            r.last = 1'b1;
            rewind_frame();
          end
        end
        default: begin
          if (b == code) begin
            rewind_frame();
            ph = lpfr_pkg::PH_LENGTH;
          end else begin
            r.status = lpfr_pkg::ST_BADSTART;
            r.last = 1'b1;
            rewind_frame();
          end
        end
      endcase
    end
    return r;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic [2:0] e, input bit typed,
                           input lpfr_pkg::result_t want);
    lpfr_pkg::result_t pred;
    while (!calm && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    in_line_errors <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = deframe(b, e);
    pending_results.push_back(typed ? want : pred);
    frame_over = pred.last;
    bytes_sent++;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_start_code(input logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    code = v;
  endtask

  function automatic logic [2:0] line_noise();
    return ($urandom_range(59) == 0) ? 3'($urandom_range(7, 1)) : 3'b000;
  endfunction

  task automatic random_frame();
    int kind;
    int len;
    int n;
    kind = $urandom_range(99);
    if (kind < 75) begin
      n = $urandom_range(99);
      if (n < 80) len = $urandom_range(12);
      else if (n < 95) len = $urandom_range(80, 13);
      else len = $urandom_range(511, 256);
      push_byte(code, line_noise(), 1'b0, NO_CHECK);
      if (!frame_over) push_byte(8'(len >> 8), line_noise(), 1'b0, NO_CHECK);
      if (!frame_over) push_byte(8'(len), line_noise(), 1'b0, NO_CHECK);
      for (int i = 0; i < len && !frame_over; i++)
        push_byte(8'($urandom), line_noise(), 1'b0, NO_CHECK);
    end else if (kind < 85) begin
      n = $urandom_range(6, 1);
      repeat (n)
        push_byte(($urandom_range(3) == 0) ? code : 8'($urandom),
                  ($urandom_range(9) < 7) ? 3'b000 : 3'($urandom_range(7)),
                  1'b0, NO_CHECK);
    end else begin
      n = $urandom_range(3);
      push_byte(code, 3'b000, 1'b0, NO_CHECK);
      repeat (n) push_byte(8'($urandom), 3'b000, 1'b0, NO_CHECK);
    end
    if ($urandom_range(39) == 0) wait_drain();
  endtask

  task automatic random_run(input int count);
    int target;
    target = bytes_sent + count;
    while (bytes_sent < target) random_frame();
  endtask

  always @(posedge clk) begin
    out_stall <= !calm && rst_n && ($urandom_range(99) < 28);
  end

  always @(posedge clk) begin
    lpfr_pkg::result_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t unexpected result: st=%0d byte=%h idx=%0d len=%0d last=%b",
                   $realtime, out_status, out_payload_byte, out_payload_index,
                   out_frame_length, out_last);
      end else begin
        w = pending_results.pop_front();
        if (out_status != w.status || out_payload_byte != w.payload_byte ||
            out_payload_index != w.payload_index || out_frame_length != w.frame_length ||
            out_last != w.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"%0t mismatch: expected st=%0d byte=%h idx=%0d len=%0d last=%b,",
                      " got st=%0d byte=%h idx=%0d len=%0d last=%b"},
                     $realtime, w.status, w.payload_byte, w.payload_index,
                     w.frame_length, w.last, out_status, out_payload_byte,
                     out_payload_index, out_frame_length, out_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("length_prefixed_frame_receiver_top_tb: FAIL");
      $finish;
    end
  end

  initial begin
    code = lpfr_pkg::START_CODE_RESET;
    rewind_frame();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++)
      push_byte(dir_tab[i].rx, dir_tab[i].errs, dir_tab[i].typed, dir_tab[i].want);
    random_run(350);

    wait_drain();
    set_start_code(8'h00);
    calm = 1'b1;
    // full 16-bit length, back to back, cut short by a line error
    push_byte(code, 3'b000, 1'b0, NO_CHECK);
    push_byte(8'hFF, 3'b000, 1'b0, NO_CHECK);
    push_byte(8'hFF, 3'b000, 1'b0, NO_CHECK);
    repeat (200) push_byte(8'($urandom), 3'b000, 1'b0, NO_CHECK);
    push_byte(8'($urandom), 3'b001, 1'b1,
              '{lpfr_pkg::ST_LINEERR, 8'h00, 16'h0000, 16'hFFFF, 1'b1});
    random_run(350);
    calm = 1'b0;

    wait_drain();
    set_start_code(8'hFF);
    random_run(350);

    wait_drain();
    set_start_code(8'($urandom));
    random_run(350);

    wait_drain();
    repeat (5) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("length_prefixed_frame_receiver_top_tb: PASS");
    else
      $display("length_prefixed_frame_receiver_top_tb: FAIL");
    $finish;
  end

endmodule

[length_prefixed_frame_receiver_top.f]
hdl/lpfr_pkg.sv
hdl/lpfr_parser.sv
hdl/lpfr_out_skid.sv
hdl/length_prefixed_frame_receiver_top.sv
hdl/lpfr_checker.sv
tb/sv/length_prefixed_frame_receiver_top_tb.sv
